// File: rtl/dual_motor_spinup_sequencer_core_macros.svh
// assertion macros for the spin-up sequencer checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef DUAL_MOTOR_SPINUP_SEQUENCER_CORE_MACROS_SVH
`define DUAL_MOTOR_SPINUP_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define DMSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dmss check failed");

// next-cycle implication, off during reset
`define DMSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dmss check failed");

// what must hold in the cycle after reset is applied
`define DMSS_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("dmss reset check failed");

`endif

// File: rtl/dmss_pkg.sv
// shared types and constants for the dual motor spin-up sequencer
// no dependencies
`default_nettype none

package dmss_pkg;

    localparam int SPEED_W = 7;
    localparam int TIME_W  = 32;
    localparam int DIR_W   = 3;
    localparam int PROD_W  = 14;
    localparam int POWER_W = 8;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;

    localparam logic [SPEED_W-1:0] PERCENT_FULL = 7'd100;
    localparam logic [12:0]        RECIP_100    = 13'd5243;
    localparam int                 RECIP_SHIFT  = 19;
    localparam logic [8:0]         POWER_MAX    = 9'd255;

    localparam logic OP_DRIVE  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [DIR_W-1:0] DIR_LEFT     = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 3'd3;
    localparam logic [DIR_W-1:0] DIR_STOP     = 3'd4;

    localparam logic [IDX_W-1:0] REG_STOP_DWELL = 2'd0;
    localparam logic [IDX_W-1:0] REG_SPIN_UP    = 2'd1;
    localparam logic [IDX_W-1:0] REG_TOP_SPEED  = 2'd2;
    localparam logic [IDX_W-1:0] REG_KICK_SPEED = 2'd3;

    typedef enum logic [3:0] {
        PH_STOPPED  = 4'b0001,
        PH_SPINUP   = 4'b0010,
        PH_RUNNING  = 4'b0100,
        PH_STOPPING = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [POWER_W-1:0] right_power;
        logic               right_low;
        logic               right_high;
        logic [POWER_W-1:0] left_power;
        logic               left_low;
        logic               left_high;
    } bridge_t;

endpackage

`default_nettype wire

// File: rtl/dmss_bridge.sv
// h-bridge levels and pwm power for both sides from speed and direction
// depends on dmss_pkg
`default_nettype none

module dmss_bridge (
    input  wire logic [dmss_pkg::SPEED_W-1:0] speed,
    input  wire logic [dmss_pkg::DIR_W-1:0]   direction,
    output dmss_pkg::bridge_t                 bridge
);
    import dmss_pkg::*;

    logic [14:0] scaled;
    logic [27:0] recip_prod;
    logic [8:0]  quot;
    logic [POWER_W-1:0] power;

    // speed * 255 / 100, saturated to 255
    assign scaled     = {speed, 8'd0} - {8'd0, speed};
    assign recip_prod = {13'd0, scaled} * {15'd0, RECIP_100};
    assign quot       = recip_prod[RECIP_SHIFT +: 9];
    assign power      = (quot > POWER_MAX) ? POWER_MAX[POWER_W-1:0] : quot[POWER_W-1:0];

    always_comb begin
        bridge.left_power  = power;
        bridge.right_power = power;
        case (direction)
            DIR_FORWARD: begin
                bridge.left_high  = 1'b1;
                bridge.left_low   = 1'b0;
                bridge.right_high = 1'b1;
                bridge.right_low  = 1'b0;
            end
            DIR_BACKWARD: begin
                bridge.left_high  = 1'b0;
                bridge.left_low   = 1'b1;
                bridge.right_high = 1'b0;
                bridge.right_low  = 1'b1;
            end
            DIR_LEFT: begin
                bridge.left_high  = 1'b1;
                bridge.left_low   = 1'b0;
                bridge.right_high = 1'b0;
                bridge.right_low  = 1'b1;
            end
            DIR_RIGHT: begin
                bridge.left_high  = 1'b0;
                bridge.left_low   = 1'b1;
                bridge.right_high = 1'b1;
                bridge.right_low  = 1'b0;
            end
            default: begin
                bridge.left_high   = 1'b1;
                bridge.left_low    = 1'b0;
                bridge.right_high  = 1'b1;
                bridge.right_low   = 1'b0;
                bridge.left_power  = '0;
                bridge.right_power = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/dual_motor_spinup_sequencer_core.sv
// dual motor spin-up sequencer: input register, one step of phase logic, result register
// a tick transaction passes the input register, then the result register
// throughput: one transaction per cycle unless a result stalls; one registered step per item
// drive transactions update the target and give no result
// reset (aresetn low, synchronous) clears phase, speeds, timers and restores register defaults
`default_nettype none

module dual_motor_spinup_sequencer_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output      logic                        s_tready,
    // direction[2:0], speed_percent[9:3], duration_ms[41:10], now_ms[73:42], zero fill
    input  wire logic [79:0]                 s_tdata,
    // operation[0]
    input  wire logic                        s_tuser,
    output      logic                        m_tvalid,
    input  wire logic                        m_tready,
    // left_high[0], left_low[1], left_power[9:2], right_high[10], right_low[11],
    // right_power[19:12], zero fill
    output      logic [23:0]                 m_tdata,
    input  wire logic                        cfg_we,
    input  wire logic [dmss_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [dmss_pkg::CFG_W-1:0]  cfg_wdata
);
    import dmss_pkg::*;

    // configuration
    logic [TIME_W-1:0]  stop_dwell_reg;
    logic [TIME_W-1:0]  spin_up_reg;
    logic [SPEED_W-1:0] top_speed_reg;
    logic [SPEED_W-1:0] kick_speed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_dwell_reg <= '0;
            spin_up_reg    <= '0;
            top_speed_reg  <= PERCENT_FULL;
            kick_speed_reg <= PERCENT_FULL;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STOP_DWELL: stop_dwell_reg <= cfg_wdata;
                REG_SPIN_UP:    spin_up_reg    <= cfg_wdata;
                REG_TOP_SPEED:  top_speed_reg  <= cfg_wdata[SPEED_W-1:0];
                REG_KICK_SPEED: kick_speed_reg <= cfg_wdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic               in_valid_reg;
    logic               in_op_reg;
    logic [DIR_W-1:0]   in_dir_reg;
    logic [PROD_W-1:0]  in_prod_reg;
    logic [TIME_W-1:0]  in_dur_reg;
    logic [TIME_W-1:0]  in_now_reg;

    logic [DIR_W-1:0]   s_dir;
    logic [SPEED_W-1:0] s_spd;
    logic               advance;
    logic               m_tvalid_reg;

    assign s_dir = (s_tdata[2:0] > DIR_STOP) ? DIR_STOP : s_tdata[2:0];
    assign s_spd = (s_tdata[9:3] > PERCENT_FULL) ? PERCENT_FULL : s_tdata[9:3];

    assign advance  = in_valid_reg && ((in_op_reg == OP_DRIVE) || !m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_dir_reg  <= s_dir;
            in_prod_reg <= {7'd0, s_spd} * {7'd0, top_speed_reg};
            in_dur_reg  <= s_tdata[41:10];
            in_now_reg  <= s_tdata[73:42];
        end
    end

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [SPEED_W-1:0] cur_speed_reg, cur_speed_next;
    logic [DIR_W-1:0]   cur_dir_reg, cur_dir_next;
    logic [SPEED_W-1:0] tgt_speed_reg, tgt_speed_next;
    logic [DIR_W-1:0]   tgt_dir_reg, tgt_dir_next;
    logic [TIME_W-1:0]  tgt_dur_reg, tgt_dur_next;
    logic [TIME_W-1:0]  last_change_reg, last_change_next;

    logic [26:0]        drive_prod;
    logic [TIME_W-1:0]  elapsed;

    // percent * top speed / 100
    assign drive_prod = {13'd0, in_prod_reg} * {14'd0, RECIP_100};
    assign elapsed    = in_now_reg - last_change_reg;

    always_comb begin
        phase_next       = phase_reg;
        cur_speed_next   = cur_speed_reg;
        cur_dir_next     = cur_dir_reg;
        tgt_speed_next   = tgt_speed_reg;
        tgt_dir_next     = tgt_dir_reg;
        tgt_dur_next     = tgt_dur_reg;
        last_change_next = last_change_reg;
        if (in_op_reg == OP_DRIVE) begin
            tgt_speed_next = drive_prod[RECIP_SHIFT +: SPEED_W];
            tgt_dir_next   = in_dir_reg;
            tgt_dur_next   = in_dur_reg;
        end else begin
            case (phase_reg)
                PH_STOPPED: begin
                    if (tgt_speed_reg != '0) begin
                        phase_next       = PH_SPINUP;
                        cur_speed_next   = kick_speed_reg;
                        cur_dir_next     = tgt_dir_reg;
                        last_change_next = in_now_reg;
                    end
                end
                PH_SPINUP: begin
                    if (elapsed >= spin_up_reg) begin
                        phase_next       = PH_RUNNING;
                        cur_speed_next   = tgt_speed_reg;
                        last_change_next = in_now_reg;
                    end
                end
                PH_RUNNING: begin
                    if ((cur_dir_reg != tgt_dir_reg) || (elapsed >= tgt_dur_reg)) begin
                        phase_next       = PH_STOPPING;
                        cur_speed_next   = '0;
                        tgt_speed_next   = '0;
                        last_change_next = in_now_reg;
                    end else if (cur_speed_reg != tgt_speed_reg) begin
                        cur_speed_next   = tgt_speed_reg;
                        last_change_next = in_now_reg;
                    end
                end
                default: begin
                    if (elapsed >= stop_dwell_reg) begin
                        phase_next = PH_STOPPED;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_STOPPED;
            cur_speed_reg   <= '0;
            cur_dir_reg     <= DIR_STOP;
            tgt_speed_reg   <= '0;
            tgt_dir_reg     <= DIR_STOP;
            tgt_dur_reg     <= '0;
            last_change_reg <= '0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            cur_speed_reg   <= cur_speed_next;
            cur_dir_reg     <= cur_dir_next;
            tgt_speed_reg   <= tgt_speed_next;
            tgt_dir_reg     <= tgt_dir_next;
            tgt_dur_reg     <= tgt_dur_next;
            last_change_reg <= last_change_next;
        end
    end

    // result stage
    bridge_t bridge;
    bridge_t bridge_reg;

    dmss_bridge u_bridge (
        .speed     (cur_speed_next),
        .direction (cur_dir_next),
        .bridge    (bridge)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance && (in_op_reg == OP_UPDATE)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (in_op_reg == OP_UPDATE)) begin
            bridge_reg <= bridge;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, bridge_reg};

endmodule

`default_nettype wire

// File: rtl/dmss_checker.sv
// port-level checks for the dual motor spin-up sequencer, bound to the top level
// depends on dual_motor_spinup_sequencer_core_macros.svh
`default_nettype none

`include "dual_motor_spinup_sequencer_core_macros.svh"

module dmss_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // a stalled result transaction holds
    `DMSS_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // each side drives exactly one leg of its bridge
    `DMSS_ASSERT_NOW(a_legs_excl, m_tvalid, (m_tdata[0] ^ m_tdata[1]) && (m_tdata[10] ^ m_tdata[11]))

    // both sides always get the same power
    `DMSS_ASSERT_NOW(a_power_equal, m_tvalid, m_tdata[9:2] == m_tdata[19:12])

    // no result transaction pending right after reset
    `DMSS_ASSERT_RESET(a_reset_empty, !m_tvalid)

endmodule

bind dual_motor_spinup_sequencer_core dmss_checker u_dmss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: dv/tb_dual_motor_spinup_sequencer_core.sv
// self-checking testbench for dual_motor_spinup_sequencer_core
// directed rows, then random command and tick streams, checked by a built-in sequencer model
// depends on rtl/dmss_pkg.sv and rtl/dual_motor_spinup_sequencer_core.sv
`timescale 1ns / 1ps

module tb_dual_motor_spinup_sequencer_core;
    import dmss_pkg::*;

    typedef struct packed {
        logic             op;
        logic [2:0]       dir;
        logic [6:0]       spd;
        logic [31:0]      dur;
        logic [31:0]      now;
        logic             typed;
        bridge_t          bridge;
    } stim_row_t;

    // bridge words that can be read off directly
    localparam bridge_t BR_IDLE      = 20'h00401;
    localparam bridge_t BR_FWD_FULL  = 20'hFF7FD;
    localparam bridge_t BR_LEFT_FULL = 20'hFFBFD;
    localparam bridge_t BR_NONE      = 20'h00000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // expectation that travels with the current transaction
    logic    row_typed = 1'b0;
    bridge_t row_bridge = '0;

    // model copy of the registers and state
    logic [31:0] dwell_ms = 32'd0;
    logic [31:0] spinup_ms = 32'd0;
    logic [6:0]  top_speed_set = 7'd100;
    logic [6:0]  kick_speed_set = 7'd100;
    phase_t      seq_phase = PH_STOPPED;
    logic [6:0]  run_speed = 7'd0;
    logic [2:0]  run_dir = DIR_STOP;
    logic [6:0]  want_speed = 7'd0;
    logic [2:0]  want_dir = DIR_STOP;
    logic [31:0] want_duration = 32'd0;
    logic [31:0] mark_ms = 32'd0;

    bridge_t     bridge_q[$];
    int unsigned mismatches = 0;
    bit          idle_on = 1'b1;
    int unsigned hold_requests = 0;
    logic [31:0] ms_clock = 32'd0;
    logic [2:0]  fav_dir = DIR_FORWARD;

    stim_row_t directed_rows [0:24] = '{
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'd0,        1'b1, BR_IDLE},
        '{OP_DRIVE,  DIR_FORWARD,  7'd127, 32'd10,       32'd0,        1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'd5,        1'b1, BR_FWD_FULL},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'd5,        1'b1, BR_FWD_FULL},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'd14,       1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'd15,       1'b1, BR_IDLE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'd15,       1'b0, BR_NONE},
        '{OP_DRIVE,  3'd7,         7'd100, 32'd0,        32'hFFFFFFFF, 1'b0, BR_NONE},
        '{OP_UPDATE, 3'd7,         7'd127, 32'hFFFFFFFF, 32'hFFFFFFF0, 1'b1, BR_IDLE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000010, 1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000010, 1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000010, 1'b0, BR_NONE},
        '{OP_DRIVE,  DIR_LEFT,     7'd1,   32'd100,      32'd0,        1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000020, 1'b1, BR_LEFT_FULL},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000020, 1'b0, BR_NONE},
        '{OP_DRIVE,  DIR_RIGHT,    7'd100, 32'hFFFFFFFF, 32'd0,        1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000021, 1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000022, 1'b0, BR_NONE},
        '{OP_DRIVE,  DIR_RIGHT,    7'd60,  32'hFFFFFFFF, 32'd0,        1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000030, 1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000030, 1'b0, BR_NONE},
        '{OP_DRIVE,  DIR_RIGHT,    7'd30,  32'hFFFFFFFF, 32'd0,        1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000040, 1'b0, BR_NONE},
        '{OP_DRIVE,  DIR_BACKWARD, 7'd0,   32'd0,        32'd0,        1'b0, BR_NONE},
        '{OP_UPDATE, DIR_STOP,     7'd0,   32'd0,        32'h00000041, 1'b0, BR_NONE}
    };

    dual_motor_spinup_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void step_sequencer(input logic op, input logic [2:0] dir,
                                           input logic [6:0] spd, input logic [31:0] dur,
                                           input logic [31:0] now, output bit gives,
                                           output bridge_t br);
        int unsigned pct;
        int unsigned pwr;
        logic [31:0] elapsed;
        logic        lrev;
        logic        rrev;
        br = '0;
        gives = 1'b0;
        if (op == OP_DRIVE) begin
            pct = (spd > 7'd100) ? 100 : int'(spd);
            want_speed = 7'(pct * top_speed_set / 100);
            want_dir = (dir > DIR_STOP) ? DIR_STOP : dir;
            want_duration = dur;
        end else begin
            gives = 1'b1;
            elapsed = now - mark_ms;
            case (seq_phase)
                PH_STOPPED: begin
                    if (want_speed != 0) begin
                        seq_phase = PH_SPINUP;
                        run_speed = kick_speed_set;
                        run_dir = want_dir;
                        mark_ms = now;
                    end
                end
                PH_SPINUP: begin
                    if (elapsed >= spinup_ms) begin
                        seq_phase = PH_RUNNING;
                        run_speed = want_speed;
                        mark_ms = now;
                    end
                end
                PH_RUNNING: begin
                    if (run_dir != want_dir || elapsed >= want_duration) begin
                        seq_phase = PH_STOPPING;
                        run_speed = 7'd0;
                        want_speed = 7'd0;
                        mark_ms = now;
                    end else if (run_speed != want_speed) begin
                        run_speed = want_speed;
                        mark_ms = now;
                    end
                end
                default: begin
                    if (elapsed >= dwell_ms) seq_phase = PH_STOPPED;
                end
            endcase
            pwr = run_speed * 255 / 100;
            if (pwr > 255) pwr = 255;
            lrev = 1'b0;
            rrev = 1'b0;
            case (run_dir)
                DIR_FORWARD: begin
                    lrev = 1'b0;
                    rrev = 1'b0;
                end
                DIR_BACKWARD: begin
                    lrev = 1'b1;
                    rrev = 1'b1;
                end
                DIR_LEFT: begin
                    lrev = 1'b0;
                    rrev = 1'b1;
                end
                DIR_RIGHT: begin
                    lrev = 1'b1;
                    rrev = 1'b0;
                end
                default: pwr = 0;
            endcase
            br.left_high = ~lrev;
            br.left_low = lrev;
            br.left_power = 8'(pwr);
            br.right_high = ~rrev;
            br.right_low = rrev;
            br.right_power = 8'(pwr);
        end
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : bridge_check
        bit      gives;
        bridge_t predicted;
        bridge_t want;
        bridge_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                step_sequencer(s_tuser, s_tdata[2:0], s_tdata[9:3], s_tdata[41:10],
                               s_tdata[73:42], gives, predicted);
                if (gives) bridge_q.push_back(row_typed ? row_bridge : predicted);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[19:0];
                if (bridge_q.size() == 0) begin
                    $error("unexpected result transaction 0x%06h", m_tdata);
                    mismatches++;
                end else begin
                    want = bridge_q.pop_front();
                    check_field("left_high", want.left_high, got.left_high);
                    check_field("left_low", want.left_low, got.left_low);
                    check_field("left_power", want.left_power, got.left_power);
                    check_field("right_high", want.right_high, got.right_high);
                    check_field("right_low", want.right_low, got.right_low);
                    check_field("right_power", want.right_power, got.right_power);
                end
            end
        end
    end

    // result side: random stalls per transaction while idle_on is set, one long hold on request
    initial begin : result_sink
        int unsigned stall;
        int unsigned holds_done;
        stall = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                stall = 300;
            end else if (m_tvalid && m_tready) begin
                stall = idle_on ? $urandom_range(0, 14) : 0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic offer(input stim_row_t row);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= row.op;
        s_tdata <= {6'd0, row.now, row.dur, row.spd, row.dir};
        row_typed <= row.typed;
        row_bridge <= row.bridge;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bridge_q.size() != 0) @(posedge aclk);
        // drive transactions leave nothing to wait on, so cover the pipeline
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [31:0] dwell, input logic [31:0] spin,
                                 input logic [6:0] maxs, input logic [6:0] kick);
        cfg_we <= 1'b1;
        cfg_index <= REG_STOP_DWELL;
        cfg_wdata <= dwell;
        @(posedge aclk);
        cfg_index <= REG_SPIN_UP;
        cfg_wdata <= spin;
        @(posedge aclk);
        cfg_index <= REG_TOP_SPEED;
        cfg_wdata <= 32'(maxs);
        @(posedge aclk);
        cfg_index <= REG_KICK_SPEED;
        cfg_wdata <= 32'(kick);
        @(posedge aclk);
        cfg_we <= 1'b0;
        dwell_ms = dwell;
        spinup_ms = spin;
        top_speed_set = maxs;
        kick_speed_set = kick;
    endtask

    function automatic stim_row_t random_item();
        stim_row_t   r;
        int unsigned pick;
        r.op = ($urandom_range(0, 9) < 7) ? OP_UPDATE : OP_DRIVE;
        r.dir = 3'($urandom);
        r.spd = 7'($urandom);
        r.dur = $urandom;
        r.now = $urandom;
        r.typed = 1'b0;
        r.bridge = '0;
        if (r.op == OP_DRIVE) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                r.dir = 3'($urandom_range(5, 7));
            end else if (pick < 5) begin
                r.dir = fav_dir;
            end else begin
                r.dir = 3'($urandom_range(0, 4));
                fav_dir = r.dir;
            end
            pick = $urandom_range(0, 7);
            if (pick == 0) r.spd = 7'($urandom_range(101, 127));
            else if (pick == 1) r.spd = 7'd0;
            else r.spd = 7'($urandom_range(1, 100));
            if ($urandom_range(0, 15) != 0) r.dur = $urandom_range(0, 60);
        end else begin
            if ($urandom_range(0, 31) == 0) ms_clock = $urandom;
            else ms_clock = ms_clock + $urandom_range(0, 8);
            r.now = ms_clock;
        end
        return r;
    endfunction

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) offer(directed_rows[i]);
        settle();

        ms_clock = 32'h00000100;
        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1: load_settings(32'd0, 32'd0, 7'd0, 7'd0);
                2: load_settings(32'hFFFFFFFF, 32'hFFFFFFFF, 7'd127, 7'd127);
                default: load_settings($urandom_range(0, 25), $urandom_range(0, 25),
                                       7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            endcase
            for (int n = 0; n < 325; n++) begin
                if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
                // back-pressure burst: sink holds off while the source streams
                if (ph == 4 && n == 0) begin
                    idle_on = 1'b0;
                    hold_requests++;
                end
                offer(random_item());
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dmss_pkg.sv
rtl/dmss_bridge.sv
rtl/dual_motor_spinup_sequencer_core.sv
rtl/dmss_checker.sv
dv/tb_dual_motor_spinup_sequencer_core.sv
